/* sv/assert_macros.svh */
// Assertion macros for the block's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/x86old_pkg.sv */
package x86old_pkg;

  typedef enum logic [4:0] {
    MN_NONE = 5'd0,
    MN_ADD  = 5'd1,
    MN_CMP  = 5'd2,
    MN_SUB  = 5'd3,
    MN_AND  = 5'd4,
    MN_CALL = 5'd5,
    MN_PUSH = 5'd6,
    MN_DEC  = 5'd7,
    MN_HLT  = 5'd8,
    MN_IN   = 5'd9,
    MN_INT  = 5'd10,
    MN_JE   = 5'd11,
    MN_JL   = 5'd12,
    MN_JMP  = 5'd13,
    MN_JNB  = 5'd14,
    MN_JNE  = 5'd15,
    MN_JNL  = 5'd16,
    MN_LEA  = 5'd17,
    MN_MOV  = 5'd18,
    MN_OR   = 5'd19,
    MN_POP  = 5'd20,
    MN_RET  = 5'd21,
    MN_SHL  = 5'd22,
    MN_NEG  = 5'd23,
    MN_TEST = 5'd24,
    MN_XOR  = 5'd25,
    MN_SBB  = 5'd26
  } mnemonic_t;

  localparam int unsigned LenW = 3;
  typedef logic [LenW-1:0] len_t;

  typedef struct packed {
    mnemonic_t mnemonic;
    len_t      length;
    logic      recognized;
  } decode_t;

  localparam len_t MaxLength = 3'd6;

endpackage

/* sv/x86old_decode.sv */
module x86old_decode
  import x86old_pkg::*;
(
  input  logic [7:0] first_byte,
  input  logic [7:0] second_byte,
  output decode_t    result
);

  logic [2:0] reg_f;
  logic [1:0] mod_f;
  logic [1:0] disp;
  len_t       d;
  mnemonic_t  mn;
  len_t       len;

  assign reg_f = second_byte[5:3];
  assign mod_f = second_byte[7:6];

  always_comb begin
    priority if (mod_f == 2'b00 && second_byte[2:0] == 3'b110) disp = 2'd2;
    else if (mod_f == 2'b01) disp = 2'd1;
    else if (mod_f == 2'b10) disp = 2'd2;
    else disp = 2'd0;
  end

  assign d = {1'b0, disp};

  always_comb begin
    mn  = MN_NONE;
    len = '0;
    priority if (first_byte[7:2] == 6'b000000) begin
      mn  = MN_ADD;
      len = 3'd2 + d;
    end else if (first_byte[7:2] == 6'b100000) begin
      priority if (reg_f == 3'd0) mn = MN_ADD;
      else if (reg_f == 3'd7) mn = MN_CMP;
      else if (reg_f == 3'd5) mn = MN_SUB;
      else mn = MN_NONE;
      len = 3'd3 + d + ((first_byte[1:0] == 2'b01) ? 3'd1 : 3'd0);
    end else if (first_byte[7:2] == 6'b001000) begin
      mn  = MN_AND;
      len = 3'd2 + d;
    end else if (first_byte == 8'hE8) begin
      mn  = MN_CALL;
      len = 3'd3;
    end else if (first_byte == 8'hFF) begin
      priority if (reg_f == 3'd6) mn = MN_PUSH;
      else if (reg_f == 3'd2) mn = MN_CALL;
      else mn = MN_NONE;
      len = 3'd2 + d;
    end else if (first_byte[7:3] == 5'b01001) begin
      mn  = MN_DEC;
      len = 3'd1;
    end else if (first_byte == 8'hF4) begin
      mn  = MN_HLT;
      len = 3'd1;
    end else if (first_byte[7:1] == 7'h72) begin
      mn  = MN_IN;
      len = 3'd2;
    end else if (first_byte[7:1] == 7'h76) begin
      mn  = MN_IN;
      len = 3'd1;
    end else if (first_byte == 8'hCD) begin
      mn  = MN_INT;
      len = 3'd2;
    end else if (first_byte == 8'h74) begin
      mn  = MN_JE;
      len = 3'd2;
    end else if (first_byte == 8'h7C) begin
      mn  = MN_JL;
      len = 3'd2;
    end else if (first_byte == 8'hE9) begin
      mn  = MN_JMP;
      len = 3'd3;
    end else if (first_byte == 8'hEB) begin
      mn  = MN_JMP;
      len = 3'd2;
    end else if (first_byte == 8'h73) begin
      mn  = MN_JNB;
      len = 3'd2;
    end else if (first_byte == 8'h75) begin
      mn  = MN_JNE;
      len = 3'd2;
    end else if (first_byte == 8'h7D) begin
      mn  = MN_JNL;
      len = 3'd2;
    end else if (first_byte == 8'h8D) begin
      mn  = MN_LEA;
      len = 3'd2 + d;
    end else if (first_byte[7:2] == 6'h22) begin
      mn  = MN_MOV;
      len = 3'd2 + d;
    end else if (first_byte[7:4] == 4'hB) begin
      mn  = MN_MOV;
      len = first_byte[3] ? 3'd3 : 3'd2;
    end else if (first_byte[7:2] == 6'h02) begin
      mn  = MN_OR;
      len = 3'd2 + d;
    end else if (first_byte[7:3] == 5'h0B) begin
      mn  = MN_POP;
      len = 3'd1;
    end else if (first_byte[7:3] == 5'h0A) begin
      mn  = MN_PUSH;
      len = 3'd1;
    end else if (first_byte == 8'hC3) begin
      mn  = MN_RET;
      len = 3'd1;
    end else if (first_byte[7:2] == 6'h34) begin
      mn  = MN_SHL;
      len = 3'd2 + d;
    end else if (first_byte[7:1] == 7'h7B) begin
      // group 3: test carries an immediate
      priority if (reg_f == 3'd3) begin
        mn  = MN_NEG;
        len = 3'd2 + d;
      end else if (reg_f == 3'd0) begin
        mn  = MN_TEST;
        len = 3'd3 + d + {2'b00, first_byte[0]};
      end else begin
        mn  = MN_NONE;
        len = 3'd2 + d;
      end
    end else if (first_byte[7:2] == 6'h0C) begin
      mn  = MN_XOR;
      len = 3'd2 + d;
    end else if (first_byte[7:2] == 6'h06) begin
      mn  = MN_SBB;
      len = 3'd2 + d;
    end else begin
      mn  = MN_NONE;
      len = '0;
    end
  end

  assign result.mnemonic   = mn;
  assign result.length     = len;
  assign result.recognized = (len != '0);

endmodule

/* sv/x86_opcode_length_decoder_unit.sv */
// 8086 instruction length decoder. Give the opcode byte and the byte after
// it with start; busy is always low, so a beat is taken every cycle. Done
// pulses for one cycle with the mnemonic code, the total length in bytes
// (0 for an unknown opcode) and the recognized flag. One result per cycle
// sustained, through an input register and a result register with the
// decode logic between them. There is no backpressure on the result side;
// a result not sampled while done is high is gone.
`include "assert_macros.svh"

module x86_opcode_length_decoder_unit
  import x86old_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] first_byte,
  input  logic [7:0] second_byte,
  output logic       done,
  output logic [4:0] mnemonic,
  output logic [2:0] length,
  output logic       recognized
);

  logic       in_valid;
  logic [7:0] b1;
  logic [7:0] b2;
  decode_t    dec;
  decode_t    res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      b1 <= first_byte;
      b2 <= second_byte;
    end
    if (in_valid) begin
      res <= dec;
    end
  end

  x86old_decode u_decode (
    .first_byte (b1),
    .second_byte(b2),
    .result     (dec)
  );

  assign mnemonic   = 5'(res.mnemonic);
  assign length     = res.length;
  assign recognized = res.recognized;

  `ASSERT_NEXT(a_done_follows, clk, rst, in_valid, done)
  `ASSERT_NEXT(a_no_spurious_done, clk, rst, !in_valid, !done)
  `ASSERT_IMPLIES(a_named_is_known, clk, rst, done && res.mnemonic != MN_NONE, recognized)
  `ASSERT_IMPLIES(a_length_max, clk, rst, done, length <= MaxLength)

endmodule

/* bench/x86_opcode_length_decoder_unit_test.sv */
module x86_opcode_length_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import x86old_pkg::*;

  localparam int unsigned RandBeats = 750;
  localparam int unsigned CalmTail = 150;
  localparam int unsigned StallLimit = 200;
  localparam int unsigned DrainCycles = 8;

  // reg-field selectors inside the group opcodes
  localparam logic [2:0] SelAdd  = 3'd0;
  localparam logic [2:0] SelCall = 3'd2;
  localparam logic [2:0] SelNeg  = 3'd3;
  localparam logic [2:0] SelSub  = 3'd5;
  localparam logic [2:0] SelPush = 3'd6;
  localparam logic [2:0] SelCmp  = 3'd7;
  localparam logic [2:0] SelTest = 3'd0;

  class length_decode_board;
    decode_t     expected_decodes[$];
    int unsigned fetches;
    int unsigned checked;
    int unsigned known_ops;
    int unsigned failures;

    function decode_t decode_opcode(logic [7:0] op, logic [7:0] mrm);
      decode_t    d;
      len_t       disp;
      logic [2:0] sel;
      sel = mrm[5:3];
      if (mrm[7:6] == 2'b00 && mrm[2:0] == 3'b110) disp = 3'd2;
      else if (mrm[7:6] == 2'b01) disp = 3'd1;
      else if (mrm[7:6] == 2'b10) disp = 3'd2;
      else disp = 3'd0;
      d.mnemonic = MN_NONE;
      d.length = '0;
      if (op[7:2] == 6'b000000) begin
        d.mnemonic = MN_ADD;
        d.length = 3'd2 + disp;
      end else if (op[7:2] == 6'b100000) begin
        if (sel == SelAdd) d.mnemonic = MN_ADD;
        else if (sel == SelCmp) d.mnemonic = MN_CMP;
        else if (sel == SelSub) d.mnemonic = MN_SUB;
        d.length = 3'd3 + disp + ((op[1:0] == 2'b01) ? 3'd1 : 3'd0);
      end else if (op[7:2] == 6'b001000) begin
        d.mnemonic = MN_AND;
        d.length = 3'd2 + disp;
      end else if (op == 8'hE8) begin
        d.mnemonic = MN_CALL;
        d.length = 3'd3;
      end else if (op == 8'hFF) begin
        if (sel == SelPush) d.mnemonic = MN_PUSH;
        else if (sel == SelCall) d.mnemonic = MN_CALL;
        d.length = 3'd2 + disp;
      end else if (op[7:3] == 5'b01001) begin
        d.mnemonic = MN_DEC;
        d.length = 3'd1;
      end else if (op == 8'hF4) begin
        d.mnemonic = MN_HLT;
        d.length = 3'd1;
      end else if (op[7:1] == 7'b1110010) begin
        d.mnemonic = MN_IN;
        d.length = 3'd2;
      end else if (op[7:1] == 7'b1110110) begin
        d.mnemonic = MN_IN;
        d.length = 3'd1;
      end else if (op == 8'hCD) begin
        d.mnemonic = MN_INT;
        d.length = 3'd2;
      end else if (op == 8'h74) begin
        d.mnemonic = MN_JE;
        d.length = 3'd2;
      end else if (op == 8'h7C) begin
        d.mnemonic = MN_JL;
        d.length = 3'd2;
      end else if (op == 8'hE9) begin
        d.mnemonic = MN_JMP;
        d.length = 3'd3;
      end else if (op == 8'hEB) begin
        d.mnemonic = MN_JMP;
        d.length = 3'd2;
      end else if (op == 8'h73) begin
        d.mnemonic = MN_JNB;
        d.length = 3'd2;
      end else if (op == 8'h75) begin
        d.mnemonic = MN_JNE;
        d.length = 3'd2;
      end else if (op == 8'h7D) begin
        d.mnemonic = MN_JNL;
        d.length = 3'd2;
      end else if (op == 8'h8D) begin
        d.mnemonic = MN_LEA;
        d.length = 3'd2 + disp;
      end else if (op[7:2] == 6'b100010) begin
        d.mnemonic = MN_MOV;
        d.length = 3'd2 + disp;
      end else if (op[7:4] == 4'b1011) begin
        d.mnemonic = MN_MOV;
        d.length = op[3] ? 3'd3 : 3'd2;
      end else if (op[7:2] == 6'b000010) begin
        d.mnemonic = MN_OR;
        d.length = 3'd2 + disp;
      end else if (op[7:3] == 5'b01011) begin
        d.mnemonic = MN_POP;
        d.length = 3'd1;
      end else if (op[7:3] == 5'b01010) begin
        d.mnemonic = MN_PUSH;
        d.length = 3'd1;
      end else if (op == 8'hC3) begin
        d.mnemonic = MN_RET;
        d.length = 3'd1;
      end else if (op[7:2] == 6'b110100) begin
        d.mnemonic = MN_SHL;
        d.length = 3'd2 + disp;
      end else if (op[7:1] == 7'b1111011) begin
        d.length = 3'd2 + disp;
        if (sel == SelNeg) begin
          d.mnemonic = MN_NEG;
        end else if (sel == SelTest) begin
          d.mnemonic = MN_TEST;
          d.length = d.length + 3'd1 + {2'b00, op[0]};
        end
      end else if (op[7:2] == 6'b001100) begin
        d.mnemonic = MN_XOR;
        d.length = 3'd2 + disp;
      end else if (op[7:2] == 6'b000110) begin
        d.mnemonic = MN_SBB;
        d.length = 3'd2 + disp;
      end
      d.recognized = (d.length != '0);
      return d;
    endfunction

    function void record_fetch(logic [7:0] op, logic [7:0] mrm);
      expected_decodes.push_back(decode_opcode(op, mrm));
      fetches++;
    endfunction

    function void compare_decode(logic [4:0] mn, logic [2:0] len, logic rec);
      decode_t want;
      if (expected_decodes.size() == 0) begin
        $error("result with no pending fetch: mnemonic %0d length %0d recognized %0b",
               mn, len, rec);
        failures++;
        return;
      end
      want = expected_decodes.pop_front();
      checked++;
      if (want.recognized) known_ops++;
      if (mn !== want.mnemonic) begin
        $error("mnemonic: expected %0d got %0d", want.mnemonic, mn);
        failures++;
      end
      if (len !== want.length) begin
        $error("length: expected %0d got %0d", want.length, len);
        failures++;
      end
      if (rec !== want.recognized) begin
        $error("recognized: expected %0b got %0b", want.recognized, rec);
        failures++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] first_byte = 8'h00;
  logic [7:0] second_byte = 8'h00;
  logic       done;
  logic [4:0] mnemonic;
  logic [2:0] length;
  logic       recognized;

  length_decode_board board = new();
  int unsigned quiet_cycles = 0;

  x86_opcode_length_decoder_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .first_byte(first_byte),
    .second_byte(second_byte),
    .done(done),
    .mnemonic(mnemonic),
    .length(length),
    .recognized(recognized)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) board.compare_decode(mnemonic, length, recognized);
      if (start && busy === 1'b0) board.record_fetch(first_byte, second_byte);
      if (done === 1'b1 || (start && busy === 1'b0)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("timeout: %0d results still pending", board.expected_decodes.size());
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  task automatic send_fetch(input logic [7:0] op, input logic [7:0] mrm);
    @(negedge clk);
    start <= 1'b1;
    first_byte <= op;
    second_byte <= mrm;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic hold_off(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  initial begin
    logic [15:0] directed[$];
    logic [7:0]  op;
    logic [7:0]  mrm;
    directed = '{16'h0000, 16'hFFFF, 16'h8106, 16'h8378, 16'h80AD, 16'h81D0,
                 16'h2186, 16'hE800, 16'hFF16, 16'hFF76, 16'h4F00, 16'hF400,
                 16'hE5AA, 16'hEC55, 16'hCD21, 16'h7410, 16'h7CF0, 16'hE901,
                 16'hEB7F, 16'h7380, 16'h7501, 16'h7D02, 16'h8D46, 16'h8B80,
                 16'hBF12, 16'h0BC8, 16'h5F00, 16'h5700, 16'hC300, 16'hD3E0,
                 16'hF7DE, 16'hF7C6, 16'hF606, 16'hF738, 16'h33C0, 16'h1A06,
                 16'h0F0F};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (i % 5 == 4) hold_off($urandom_range(1, 3));
      send_fetch(directed[i][15:8], directed[i][7:0]);
    end

    for (int unsigned n = 0; n < RandBeats; n++) begin
      if (n < RandBeats - CalmTail && (n / 64) % 2 == 0 && $urandom_range(0, 3) == 0)
        hold_off($urandom_range(1, 3));
      op = 8'($urandom_range(0, 255));
      mrm = 8'($urandom_range(0, 255));
      // most beats carry a known opcode so the group and ModR/M paths get exercised
      if ($urandom_range(0, 9) < 7)
        while (!board.decode_opcode(op, mrm).recognized) op = 8'($urandom_range(0, 255));
      send_fetch(op, mrm);
    end
    @(negedge clk);
    start <= 1'b0;

    while (board.expected_decodes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("decoded %0d fetches, %0d results checked", board.fetches, board.checked);
    $display("%0d known opcodes, %0d unknown", board.known_ops,
             board.checked - board.known_ops);
    if (board.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
